// ===== rtl/mpht_pkg.sv =====
// mpht_pkg: shared types and constants of the modulo-probe hash table.
// Used by mpht_mod and modulo_probe_hash_table_top; no dependencies.
package mpht_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int BASE_W    = 11;
	localparam int BASE_RST  = 16;

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_LOOKUP  = 2'd1;
	localparam logic [1:0] OP_DELETE  = 2'd2;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_KEYZERO  = 2'd3;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_WAIT,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

endpackage

// ===== rtl/mpht_ram.sv =====
// mpht_ram: generic single-port RAM, registered read.
// No dependencies.
module mpht_ram #(
	parameter int W = 32,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] addr,
	input  logic [W-1:0]         wdata,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== rtl/mpht_mod.sv =====
// mpht_mod: iterative key mod divisor unit, one quotient bit per cycle.
// Depends on mpht_pkg.
module mpht_mod #(
	parameter int SW = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mpht_pkg::KEY_W-1:0] key,
	input  logic [SW-1:0]              divisor,
	output logic                       done,
	output logic [SW-1:0]              rem
);
	import mpht_pkg::*;

	localparam int CW = $clog2(KEY_W + 1);

	logic [KEY_W-1:0] key_q;
	logic [SW-1:0]    rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [SW:0]      trial;

	assign trial = {rem_q, key_q[KEY_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(KEY_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			rem_q <= '0;
		end else if (busy_q) begin
			key_q <= {key_q[KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= SW'(trial - {1'b0, divisor});
			end else begin
				rem_q <= SW'(trial);
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

// ===== rtl/modulo_probe_hash_table_top.sv =====
// Modulo-probe hash table: key/value store probed at key mod d, d = base, 2*base, ...
// Depends on mpht_pkg, mpht_mod, mpht_ram.
//
// Each probe runs the bit-serial modulo unit, then one RAM read, then one check. An
// operation makes up to size/base probes for lookup/delete and up to DEPTH/base for
// an insert that grows the table. Key zero and unknown kinds skip the probes and
// go straight to the done state. After reset and after every base_size write the key
// store is swept clear, one entry per cycle; no transaction is taken meanwhile. One
// operation is in flight at a time; a result may wait in the output register while
// the next operation is accepted.
module modulo_probe_hash_table_top #(
	parameter int DEPTH = mpht_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key[31:0], value[63:32]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // value_out[31:0], size_now[42:32], zero pad
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mpht_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int SW = $clog2(DEPTH + 1) + 1;

	state_t state_q, state_d;

	logic [BASE_W-1:0] base_q;
	logic [SW-1:0]     eff_base;
	logic [SW-1:0]     size_q;
	logic [SW-1:0]     sz0_q;
	logic [SW-1:0]     d_q;
	logic [SW-1:0]     g_q;
	logic [SW-1:0]     d_next;
	logic              phase_q;
	logic              hit_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     ix_q;
	logic [1:0]        op_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [1:0]        res_status_q;
	logic [VAL_W-1:0]  res_val_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [VAL_W-1:0]  out_val_q;
	logic [BASE_W-1:0] out_size_q;
	logic              cfg_wr;
	logic              accept;
	logic              mod_done;
	logic [SW-1:0]     mod_rem;
	logic [AW-1:0]     ram_addr;
	logic              key_we;
	logic              val_we;
	logic [KEY_W-1:0]  key_wdata;
	logic [KEY_W-1:0]  rd_key;
	logic [VAL_W-1:0]  rd_val;
	logic              chk_done;
	logic              chk_write;
	logic [1:0]        chk_status;
	logic              ix_free;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : 32'(base_q);

	always_comb begin
		if (base_q == '0) begin
			eff_base = SW'(1);
		end else if (32'(base_q) > 32'(DEPTH)) begin
			eff_base = SW'(DEPTH);
		end else begin
			eff_base = SW'(base_q);
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign d_next   = d_q + eff_base;
	assign ix_free  = (32'(ix_q) >= 32'(sz0_q)) || (rd_key == '0);

	mpht_mod #(.SW(SW)) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_START),
		.key     (key_q),
		.divisor (d_q),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	assign ram_addr  = (state_q == S_CLEAR) ? clr_q : ix_q;
	assign key_we    = (state_q == S_CLEAR) || chk_write;
	assign key_wdata = (state_q == S_CLEAR || op_q == OP_DELETE) ? '0 : key_q;
	assign val_we    = chk_write && (op_q == OP_INSERT);

	mpht_ram #(.W(KEY_W), .D(DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.addr  (ram_addr),
		.wdata (key_wdata),
		.rdata (rd_key)
	);

	mpht_ram #(.W(VAL_W), .D(DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.addr  (ram_addr),
		.wdata (val_q),
		.rdata (rd_val)
	);

	// probe decision
	always_comb begin
		chk_done   = 1'b0;
		chk_write  = 1'b0;
		chk_status = ST_NOTFOUND;
		if (state_q == S_CHECK) begin
			case (op_q)
				OP_INSERT: begin
					if (!phase_q && rd_key == '0) begin
						chk_write  = 1'b1;
						chk_done   = 1'b1;
						chk_status = ST_OK;
					end else if (phase_q && ix_free) begin
						chk_write  = 1'b1;
						chk_done   = 1'b1;
						chk_status = ST_OK;
					end else if (!phase_q && d_next > sz0_q) begin
						if (32'(sz0_q) * 2 > 32'(DEPTH)) begin
							chk_done   = 1'b1;
							chk_status = ST_FULL;
						end
					end else if (phase_q && d_next > g_q) begin
						if (32'(g_q) * 2 > 32'(DEPTH)) begin
							chk_done   = 1'b1;
							chk_status = ST_FULL;
						end
					end
				end
				OP_LOOKUP: begin
					if (rd_key == key_q) begin
						chk_done   = 1'b1;
						chk_status = ST_OK;
					end else if (d_next > size_q) begin
						chk_done = 1'b1;
					end
				end
				default: begin
					chk_write = (rd_key == key_q);
					if (d_next > size_q) begin
						chk_done   = 1'b1;
						chk_status = (hit_q || rd_key == key_q) ? ST_OK : ST_NOTFOUND;
					end
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					if (s_tdata[31:0] == '0 || s_tuser == OP_UNKNOWN) begin
						state_d = S_DONE;
					end else begin
						state_d = S_START;
					end
				end
			end
			S_START: state_d = S_WAIT;
			S_WAIT:  if (mod_done) state_d = S_READ;
			S_READ:  state_d = S_CHECK;
			S_CHECK: state_d = chk_done ? S_DONE : S_START;
			S_DONE:  if (!out_valid_q || m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (cfg_wr) begin
			state_d = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			base_q      <= BASE_W'(BASE_RST);
			size_q      <= SW'(BASE_RST < DEPTH ? BASE_RST : DEPTH);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				base_q <= pwdata[BASE_W-1:0];
				clr_q  <= '0;
				if (pwdata[BASE_W-1:0] == '0) begin
					size_q <= SW'(1);
				end else if (32'(pwdata[BASE_W-1:0]) > 32'(DEPTH)) begin
					size_q <= SW'(DEPTH);
				end else begin
					size_q <= SW'(pwdata[BASE_W-1:0]);
				end
			end else if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (chk_done && chk_write && op_q == OP_INSERT && phase_q) begin
				size_q <= g_q;
			end
			if (state_q == S_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= s_tuser;
			key_q        <= s_tdata[31:0];
			val_q        <= s_tdata[63:32];
			d_q          <= eff_base;
			sz0_q        <= size_q;
			phase_q      <= 1'b0;
			hit_q        <= 1'b0;
			res_val_q    <= '0;
			res_status_q <= (s_tdata[31:0] == '0) ? ST_KEYZERO : ST_NOTFOUND;
		end
		if (state_q == S_WAIT && mod_done) begin
			ix_q <= mod_rem[AW-1:0];
		end
		if (state_q == S_CHECK) begin
			if (chk_write) begin
				hit_q <= 1'b1;
			end
			if (chk_done) begin
				res_status_q <= chk_status;
				if (op_q == OP_LOOKUP && chk_status == ST_OK) begin
					res_val_q <= rd_val;
				end
			end else if (op_q == OP_INSERT && !phase_q && d_next > sz0_q) begin
				phase_q <= 1'b1;
				d_q     <= sz0_q + eff_base;
				g_q     <= SW'(32'(sz0_q) * 2);
			end else if (op_q == OP_INSERT && phase_q && d_next > g_q) begin
				d_q <= d_next;
				g_q <= SW'(32'(g_q) * 2);
			end else begin
				d_q <= d_next;
			end
		end
		if (state_q == S_DONE && (!out_valid_q || m_tready)) begin
			out_status_q <= res_status_q;
			out_val_q    <= res_val_q;
			out_size_q   <= BASE_W'(size_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {5'd0, out_size_q, out_val_q};

	a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == S_WAIT)
		else $error("modulo result outside wait state");
	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(size_q) <= 32'(DEPTH)) && (size_q != '0))
		else $error("size in use out of range");
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !s_tready)
		else $error("transaction accepted during clear sweep");
	a_write_only_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		val_we |-> state_q == S_CHECK && op_q == OP_INSERT)
		else $error("value write outside insert check");
endmodule
